FILE: design/jaxis_pkg.sv
`default_nettype none

package jaxis_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned WIN_W      = 6;
  localparam int unsigned SPAN_W     = 12;
  localparam int unsigned TRIM_W     = 10;
  localparam int unsigned DEAD_W     = 14;
  localparam int unsigned PCT_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  // signed block numerator: sum - W*span_low + W*mid_trim
  localparam int unsigned NUM_W      = 19;

  // shared divider: 32-bit dividend, 17-bit divisor, one quotient bit a step
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DVS_W      = 17;
  localparam int unsigned DIV_CNT_W  = 5;

  // queue of finished block sums between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  localparam logic [WIN_W-1:0]  MAX_WINDOW = 6'd32;
  localparam logic [PCT_W-1:0]  HALF_Q8    = 15'd12800;
  localparam logic [PCT_W-1:0]  FULL_Q8    = 15'd25600;
  localparam logic [DEAD_W-1:0] DEAD_MAX   = 14'd12799;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW   = 3'd0,
    CFG_SPAN_LOW = 3'd1,
    CFG_SPAN_HI  = 3'd2,
    CFG_TRIM     = 3'd3,
    CFG_DEAD     = 3'd4,
    CFG_DEAD_EN  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [WIN_W-1:0]         window_size;
    logic [SPAN_W-1:0]        span_low;
    logic [SPAN_W-1:0]        span_high;
    logic signed [TRIM_W-1:0] mid_trim;
    logic [DEAD_W-1:0]        dead_band;
    logic                     dead_band_enable;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREP,
    BK_SCALE,
    BK_DIV1,
    BK_BAND,
    BK_DIV2,
    BK_OUT
  } back_state_e;

endpackage

`default_nettype wire

FILE: design/joystick_axis_average_scale_deadzone.sv
// Channel   Direction  Handshake                 Payload
// samples   in         push / full               sample_i[11:0]
// results   out        empty / pop               percent_q8_o[14:0], span_error_o
// config    in         cfg_we_i (no wait)        cfg_idx_i[2:0], cfg_data_i[13:0]
//
// A sample is taken in every cycle in which push is high and full is low; the front sums it at once.
// Each block of window_size samples yields one result; the shared 32-step
// divider runs once per block, again when the deadzone rescales a side, and
// not at all when the span is invalid.
// A two-entry queue of block sums and a one-entry result register let either
// side stall on its own; full rises only when both queued sums still wait.
// Reset is asynchronous and active low, restores the register defaults and
// needs no clearing pass.
`default_nettype none

module joystick_axis_average_scale_deadzone
  import jaxis_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [PCT_W-1:0]           percent_q8_o,
  output logic                       span_error_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t             cfg_q, cfg_d;
  logic             win_clear;
  logic             in_accept;
  logic             blk_push;
  logic [SUM_W-1:0] blk_sum;
  logic             q_full, q_empty, q_pop;
  logic [SUM_W-1:0] q_data;

  // Register writes: drop out-of-range window and deadzone values, drop
  // unknown indices, and restart the running block on a window change.
  always_comb begin
    cfg_d     = cfg_q;
    win_clear = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW: begin
          if ((cfg_data_i[WIN_W-1:0] != '0) && (cfg_data_i[WIN_W-1:0] <= MAX_WINDOW)) begin
            cfg_d.window_size = cfg_data_i[WIN_W-1:0];
            win_clear         = 1'b1;
          end
        end
        CFG_SPAN_LOW: begin
          cfg_d.span_low = cfg_data_i[SPAN_W-1:0];
        end
        CFG_SPAN_HI: begin
          cfg_d.span_high = cfg_data_i[SPAN_W-1:0];
        end
        CFG_TRIM: begin
          cfg_d.mid_trim = $signed(cfg_data_i[TRIM_W-1:0]);
        end
        CFG_DEAD: begin
          if (cfg_data_i[DEAD_W-1:0] <= DEAD_MAX) begin
            cfg_d.dead_band = cfg_data_i[DEAD_W-1:0];
          end
        end
        CFG_DEAD_EN: begin
          cfg_d.dead_band_enable = cfg_data_i[0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size      <= 6'd20;
      cfg_q.span_low         <= 12'd1568;
      cfg_q.span_high        <= 12'd3163;
      cfg_q.mid_trim         <= -10'sd107;
      cfg_q.dead_band        <= '0;
      cfg_q.dead_band_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Take a request whenever the sum queue has room.
  assign full      = q_full;
  assign in_accept = push && !q_full;

  jaxis_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .sample_i (sample_i),
    .window_i (cfg_q.window_size),
    .clear_i  (win_clear),
    .push_o   (blk_push),
    .sum_o    (blk_sum)
  );

  jaxis_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (blk_push),
    .data_i  (blk_sum),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  jaxis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (q_empty),
    .fifo_data_i  (q_data),
    .fifo_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .percent_q8_o (percent_q8_o),
    .span_error_o (span_error_o)
  );

endmodule

`default_nettype wire

FILE: design/jaxis_front.sv
`default_nettype none

module jaxis_front
  import jaxis_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic [WIN_W-1:0]    window_i,
  input  wire logic                clear_i,
  output logic                     push_o,
  output logic [SUM_W-1:0]         sum_o
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [WIN_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_nxt;
  logic [WIN_W-1:0] cnt_nxt;
  logic             blk_end;

  always_comb begin
    sum_nxt = sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, sample_i};
    cnt_nxt = cnt_q + 1'b1;
    blk_end = (cnt_nxt >= window_i);
    push_o  = accept_i && blk_end;
    sum_o   = sum_nxt;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    if (clear_i) begin
      sum_d = '0;
      cnt_d = '0;
    end else if (accept_i) begin
      // close the block on its last sample, else keep summing
      if (blk_end) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_nxt;
        cnt_d = cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/jaxis_fifo.sv
`default_nettype none

module jaxis_fifo
  import jaxis_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [SUM_W-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output logic [SUM_W-1:0]      data_o
);

  logic [SUM_W-1:0]      mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  always_comb begin
    full_o   = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
    empty_o  = (cnt_q == '0);
    data_o   = mem_q[rd_ptr_q];
    do_push  = push_i && !full_o;
    do_pop   = pop_i && !empty_o;
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/jaxis_div.sv
`default_nettype none

module jaxis_div
  import jaxis_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DVS_W-1:0]     rem_q, dvs_q;
  logic [DVS_W:0]       shifted, diff;
  logic                 ge;
  logic                 last;

  always_comb begin
    shifted    = {rem_q, quo_q[DIV_W-1]};
    diff       = shifted - {1'b0, dvs_q};
    ge         = (shifted >= {1'b0, dvs_q});
    last       = busy_q && (cnt_q == '0);
    busy_o     = busy_q;
    done_o     = done_q;
    quotient_o = quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W - 1);
      end else if (last) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // restoring division: shift in one dividend bit, subtract where it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/jaxis_back.sv
`default_nettype none

module jaxis_back
  import jaxis_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             fifo_empty_i,
  input  wire logic [SUM_W-1:0] fifo_data_i,
  output logic                  fifo_pop_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic [PCT_W-1:0]      percent_q8_o,
  output logic                  span_error_o
);

  back_state_e state_q, state_d;

  logic [SUM_W-1:0]        sum_q, sum_d;
  logic signed [NUM_W-1:0] num_q, num_d;
  logic [DVS_W-1:0]        den_q, den_d;
  logic [PCT_W-1:0]        qv_q, qv_d;
  logic [PCT_W-1:0]        res_q, res_d;
  logic                    err_q, err_d;
  logic                    upper_q, upper_d;

  logic                    out_valid_q, out_valid_d;
  logic [PCT_W-1:0]        out_pct_q;
  logic                    out_err_q;
  logic                    out_free, out_load;

  logic                    div_start, div_busy, div_done;
  logic [DIV_W-1:0]        div_dvd, div_quo;
  logic [DVS_W-1:0]        div_dvs;

  logic [NUM_W-2:0]        wlo;
  logic signed [NUM_W-1:0] w_s, trim_s, num_c;
  logic [DVS_W-1:0]        den_c;
  logic [DIV_W-1:0]        scaled;
  logic [PCT_W-1:0]        h_minus_d, h_plus_d;
  logic                    in_band, is_upper;
  logic [DEAD_W-1:0]       dz_op;
  logic [DIV_W-1:0]        dz_prod;

  jaxis_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // datapath terms
  always_comb begin
    wlo     = {{(NUM_W-1-WIN_W){1'b0}}, cfg_i.window_size}
            * {{(NUM_W-1-SPAN_W){1'b0}}, cfg_i.span_low};
    w_s     = $signed({{(NUM_W-WIN_W){1'b0}}, cfg_i.window_size});
    trim_s  = {{(NUM_W-TRIM_W){cfg_i.mid_trim[TRIM_W-1]}}, cfg_i.mid_trim};
    num_c   = $signed({{(NUM_W-SUM_W){1'b0}}, sum_q}) - $signed({1'b0, wlo})
            + w_s * trim_s;
    den_c   = {{(DVS_W-WIN_W){1'b0}}, cfg_i.window_size}
            * {{(DVS_W-SPAN_W){1'b0}}, 12'(cfg_i.span_high - cfg_i.span_low)};
    scaled  = {{(DIV_W-NUM_W+1){1'b0}}, num_q[NUM_W-2:0]} * DIV_W'(FULL_Q8);

    h_minus_d = HALF_Q8 - {1'b0, cfg_i.dead_band};
    h_plus_d  = HALF_Q8 + {1'b0, cfg_i.dead_band};
    in_band   = (qv_q > h_minus_d) && (qv_q < h_plus_d);
    is_upper  = (qv_q >= h_plus_d);
    dz_op     = is_upper ? DEAD_W'(qv_q - h_plus_d) : qv_q[DEAD_W-1:0];
    dz_prod   = {{(DIV_W-DEAD_W){1'b0}}, dz_op} * DIV_W'(HALF_Q8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    num_q   <= num_d;
    den_q   <= den_d;
    qv_q    <= qv_d;
    res_q   <= res_d;
    err_q   <= err_d;
    upper_q <= upper_d;
    if (out_load) begin
      out_pct_q <= res_q;
      out_err_q <= err_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    sum_d      = sum_q;
    num_d      = num_q;
    den_d      = den_q;
    qv_d       = qv_q;
    res_d      = res_q;
    err_d      = err_q;
    upper_d    = upper_q;
    fifo_pop_o = 1'b0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    out_free   = !out_valid_q || pop_i;
    out_load   = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          sum_d      = fifo_data_i;
          state_d    = BK_PREP;
        end
      end
      BK_PREP: begin
        if (cfg_i.span_high <= cfg_i.span_low) begin
          res_d   = '0;
          err_d   = 1'b1;
          state_d = BK_OUT;
        end else begin
          num_d   = num_c;
          den_d   = den_c;
          err_d   = 1'b0;
          state_d = BK_SCALE;
        end
      end
      BK_SCALE: begin
        // a negative numerator ends at zero after clamping
        div_start = 1'b1;
        div_dvd   = num_q[NUM_W-1] ? '0 : scaled;
        div_dvs   = den_q;
        state_d   = BK_DIV1;
      end
      BK_DIV1: begin
        if (div_done) begin
          qv_d    = (div_quo > DIV_W'(FULL_Q8)) ? FULL_Q8 : div_quo[PCT_W-1:0];
          state_d = BK_BAND;
        end
      end
      BK_BAND: begin
        if (!cfg_i.dead_band_enable) begin
          res_d   = qv_q;
          state_d = BK_OUT;
        end else if (in_band) begin
          res_d   = HALF_Q8;
          state_d = BK_OUT;
        end else begin
          upper_d   = is_upper;
          div_start = 1'b1;
          div_dvd   = dz_prod;
          div_dvs   = {{(DVS_W-DEAD_W){1'b0}}, h_minus_d[DEAD_W-1:0]};
          state_d   = BK_DIV2;
        end
      end
      BK_DIV2: begin
        if (div_done) begin
          res_d   = upper_q ? HALF_Q8 + div_quo[PCT_W-1:0] : div_quo[PCT_W-1:0];
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign empty_o      = !out_valid_q;
  assign percent_q8_o = out_pct_q;
  assign span_error_o = out_err_q;

  a_pct_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pct_q <= FULL_Q8))
    else $error("result above full scale");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_pct_q == '0))
    else $error("span error with non-zero result");

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_band_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_BAND) |-> (qv_q <= FULL_Q8))
    else $error("scaled value not clamped before deadzone");

endmodule

`default_nettype wire
